>>> hw/rtl/modular_power_ternary_digits_top_assert.svh
// Assertion macros for the modular power block with ternary exponent digits.
// Included by the top level; the macros refer to its clock and reset ports.
`ifndef MODULAR_POWER_TERNARY_DIGITS_TOP_ASSERT_SVH
`define MODULAR_POWER_TERNARY_DIGITS_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPTD_CHECK_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MPTD_CHECK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

>>> hw/rtl/mptd_pkg.sv
// Shared types and codes for the modular power block with ternary exponent digits.
// Used by the controller, the datapath and the top level; depends on nothing.
package mptd_pkg;

   // Datapath operation codes.
   typedef logic [2:0] op_type;
   localparam op_type OP_NONE     = 3'd0;
   localparam op_type OP_RED_POW  = 3'd1;
   localparam op_type OP_RED_ACC  = 3'd2;
   localparam op_type OP_MUL_ACC  = 3'd3;
   localparam op_type OP_MUL_SQ   = 3'd4;
   localparam op_type OP_MUL_CUBE = 3'd5;

   // Ternary digit values that call for accumulator products.
   localparam logic [1:0] DIGIT_ONE = 2'd1;
   localparam logic [1:0] DIGIT_TWO = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic   load;
      logic   start;
      op_type op;
      logic   emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic       busy;
      logic       done;
      logic [1:0] digit;
      logic       last;
   } status_type;

endpackage

>>> hw/rtl/modular_power_ternary_digits_top.sv
// Top level of the modular power block with ternary exponent digits, radix-3 right to left.
// Instantiates mptd_ctrl and mptd_datapath; uses mptd_pkg and the assertion macro header.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_tvalid/tready     tdata: base_value, digit; tuser: first_digit;
//                                             tlast: last_digit
//   rsp      out        rsp_tvalid/tready     tdata: power_mod
//   csr      in         csr_valid/csr_ready   csr_data: modulus
//
// Each request runs a reduction of the power and k = 2..4 products, each through the reducer;
// a last digit adds a final reduction of the accumulator and the load of the output register;
// the remainder unit handles one dividend bit per cycle.
// Reset is synchronous and active high; it sets the modulus and the accumulator to one.
// A finished response waits in the output register while the next request is taken;
// a last digit does not finish until that register is free. csr_ready is always high.
module modular_power_ternary_digits_top #(
   parameter int VALUE_WIDTH = 30,
   localparam int REQ_DATA_W = ((VALUE_WIDTH + 2 + 7) / 8) * 8,
   localparam int RSP_DATA_W = ((VALUE_WIDTH + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // base_value, digit (2 bits), zero padding
   input  logic                   req_tuser,   // first_digit
   input  logic                   req_tlast,   // last_digit
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // power_mod, zero padding
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [VALUE_WIDTH-1:0] csr_data
);

`include "modular_power_ternary_digits_top_assert.svh"

   mptd_pkg::cmd_type      cmd;
   mptd_pkg::status_type   status;
   logic [VALUE_WIDTH-1:0] power_mod;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   mptd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .cmd       (cmd),
      .status    (status)
   );

   mptd_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_write   (csr_valid),
      .csr_data    (csr_data),
      .base_value  (req_tdata[VALUE_WIDTH-1:0]),
      .digit       (req_tdata[VALUE_WIDTH+1:VALUE_WIDTH]),
      .first_digit (req_tuser),
      .last_digit  (req_tlast),
      .power_mod   (power_mod)
   );

   assign rsp_tdata = RSP_DATA_W'(power_mod);

   // A request is only taken while no reduction is running.
   `MPTD_CHECK_SAME(a_req_when_quiet, req_tvalid && req_tready, !status.busy)
   // The controller never launches an operation over one still in flight.
   `MPTD_CHECK_SAME(a_start_when_quiet, cmd.start, !status.busy)
   // Loading the output register always presents a response next cycle.
   `MPTD_CHECK_NEXT(a_emit_shows, cmd.emit, rsp_tvalid)
   // After taking a request the block is busy with it.
   `MPTD_CHECK_NEXT(a_busy_after_req, req_tvalid && req_tready, !req_tready)

endmodule

>>> hw/rtl/mptd_datapath.sv
// Datapath: modulus register, exponentiation state, multiplier and a bit-serial reducer.
// Depends on mptd_pkg for command and status types and operation codes.
module mptd_datapath #(
   parameter int VALUE_WIDTH = 30
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mptd_pkg::cmd_type      cmd,
   output mptd_pkg::status_type   status,
   input  logic                   csr_write,
   input  logic [VALUE_WIDTH-1:0] csr_data,
   input  logic [VALUE_WIDTH-1:0] base_value,
   input  logic [1:0]             digit,
   input  logic                   first_digit,
   input  logic                   last_digit,
   output logic [VALUE_WIDTH-1:0] power_mod
);

   localparam int PROD_W = 2 * VALUE_WIDTH;
   localparam int CNT_W  = $clog2(PROD_W + 1);

   logic [VALUE_WIDTH-1:0] mod_ff, mod_in;
   logic [VALUE_WIDTH-1:0] power_ff, power_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [VALUE_WIDTH-1:0] tmp_ff, tmp_in;
   logic [VALUE_WIDTH-1:0] out_ff, out_in;
   logic [1:0]             digit_ff, digit_in;
   logic                   last_ff, last_in;
   logic [PROD_W-1:0]      div_ff, div_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   mptd_pkg::op_type       op_ff, op_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   logic [VALUE_WIDTH-1:0] eff_mod;
   logic [VALUE_WIDTH-1:0] mul_a, mul_b;
   logic [PROD_W-1:0]      product;
   logic [PROD_W-1:0]      start_div;
   logic [CNT_W-1:0]       start_len;
   logic [VALUE_WIDTH:0]   trial;
   logic [VALUE_WIDTH-1:0] rem_step;

   // A modulus of zero behaves as a modulus of one.
   assign eff_mod = (mod_ff == '0) ? VALUE_WIDTH'(1) : mod_ff;

   // Operand selection and the single multiplier.
   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      start_div = '0;
      start_len = '0;
      case (cmd.op)
         mptd_pkg::OP_RED_POW: begin
            start_div = {power_ff, {VALUE_WIDTH{1'b0}}};
            start_len = CNT_W'(VALUE_WIDTH);
         end
         mptd_pkg::OP_RED_ACC: begin
            start_div = {acc_ff, {VALUE_WIDTH{1'b0}}};
            start_len = CNT_W'(VALUE_WIDTH);
         end
         mptd_pkg::OP_MUL_ACC: begin
            mul_a     = acc_ff;
            mul_b     = power_ff;
            start_len = CNT_W'(PROD_W);
         end
         mptd_pkg::OP_MUL_SQ: begin
            mul_a     = power_ff;
            mul_b     = power_ff;
            start_len = CNT_W'(PROD_W);
         end
         mptd_pkg::OP_MUL_CUBE: begin
            mul_a     = tmp_ff;
            mul_b     = power_ff;
            start_len = CNT_W'(PROD_W);
         end
         default: begin
            start_len = '0;
         end
      endcase
      product = PROD_W'(mul_a) * PROD_W'(mul_b);
      if (start_len == CNT_W'(PROD_W)) begin
         start_div = product;
      end
   end

   // One restoring remainder step: shift in the next dividend bit, subtract if it fits.
   always_comb begin
      trial = {rem_ff, div_ff[PROD_W-1]};
      if (trial >= {1'b0, eff_mod}) begin
         rem_step = VALUE_WIDTH'(trial - {1'b0, eff_mod});
      end else begin
         rem_step = trial[VALUE_WIDTH-1:0];
      end
   end

   // Next-state logic for all datapath registers.
   always_comb begin
      mod_in   = mod_ff;
      power_in = power_ff;
      acc_in   = acc_ff;
      tmp_in   = tmp_ff;
      out_in   = out_ff;
      digit_in = digit_ff;
      last_in  = last_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;

      if (csr_write) begin
         mod_in = csr_data;
      end

      // Take a new request; a start digit loads the base and resets the accumulator.
      if (cmd.load) begin
         digit_in = digit;
         last_in  = last_digit;
         if (first_digit) begin
            power_in = base_value;
            acc_in   = VALUE_WIDTH'(1);
         end
      end

      // Launch a reduction, or advance the one in flight.
      if (cmd.start) begin
         div_in  = start_div;
         rem_in  = '0;
         cnt_in  = start_len;
         op_in   = cmd.op;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         div_in = div_ff << 1;
         rem_in = rem_step;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            // The reduced accumulator only feeds the response, so the state keeps its value.
            case (op_ff)
               mptd_pkg::OP_RED_POW,
               mptd_pkg::OP_MUL_CUBE: power_in = rem_step;
               mptd_pkg::OP_MUL_ACC:  acc_in = rem_step;
               mptd_pkg::OP_RED_ACC,
               mptd_pkg::OP_MUL_SQ:   tmp_in = rem_step;
               default:               tmp_in = tmp_ff;
            endcase
         end
      end

      if (cmd.emit) begin
         out_in = tmp_ff;
      end
   end

   // The modulus, power, accumulator, busy and done registers are reset; the others are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff   <= VALUE_WIDTH'(1);
         power_ff <= '0;
         acc_ff   <= VALUE_WIDTH'(1);
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         mod_ff   <= mod_in;
         power_ff <= power_in;
         acc_ff   <= acc_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      tmp_ff   <= tmp_in;
      out_ff   <= out_in;
      digit_ff <= digit_in;
      last_ff  <= last_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      op_ff    <= op_in;
   end

   assign status.busy  = busy_ff;
   assign status.done  = done_ff;
   assign status.digit = digit_ff;
   assign status.last  = last_ff;
   assign power_mod    = out_ff;

endmodule

>>> hw/rtl/mptd_ctrl.sv
// Controller: sequences the reductions and products of one digit and the response.
// Depends on mptd_pkg for command and status types and operation codes.
module mptd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mptd_pkg::cmd_type    cmd,
   input  mptd_pkg::status_type status
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RPOW  = 3'd1;
   localparam logic [2:0] S_RACC  = 3'd2;
   localparam logic [2:0] S_MULA1 = 3'd3;
   localparam logic [2:0] S_MULA2 = 3'd4;
   localparam logic [2:0] S_SQ    = 3'd5;
   localparam logic [2:0] S_CUBE  = 3'd6;
   localparam logic [2:0] S_EMIT  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       issued_ff, issued_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic             in_op;
   mptd_pkg::op_type op_sel;
   logic [2:0]       op_next;
   logic             digit_mul;

   assign digit_mul = (status.digit == mptd_pkg::DIGIT_ONE) ||
                      (status.digit == mptd_pkg::DIGIT_TWO);

   // Operation and successor for each arithmetic state.
   always_comb begin
      in_op   = 1'b1;
      op_sel  = mptd_pkg::OP_NONE;
      op_next = S_IDLE;
      case (state_ff)
         S_RPOW: begin
            op_sel  = mptd_pkg::OP_RED_POW;
            op_next = digit_mul ? S_MULA1 : S_SQ;
         end
         S_MULA1: begin
            op_sel  = mptd_pkg::OP_MUL_ACC;
            op_next = (status.digit == mptd_pkg::DIGIT_TWO) ? S_MULA2 : S_SQ;
         end
         S_MULA2: begin
            op_sel  = mptd_pkg::OP_MUL_ACC;
            op_next = S_SQ;
         end
         S_SQ: begin
            op_sel  = mptd_pkg::OP_MUL_SQ;
            op_next = S_CUBE;
         end
         S_CUBE: begin
            op_sel  = mptd_pkg::OP_MUL_CUBE;
            op_next = status.last ? S_RACC : S_IDLE;
         end
         // On a last digit the accumulator is reduced once more for the response.
         S_RACC: begin
            op_sel  = mptd_pkg::OP_RED_ACC;
            op_next = S_EMIT;
         end
         default: begin
            in_op = 1'b0;
         end
      endcase
   end

   // State transitions and commands.
   always_comb begin
      state_in     = state_ff;
      issued_in    = issued_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.load     = 1'b0;
      cmd.start    = 1'b0;
      cmd.op       = op_sel;
      cmd.emit     = 1'b0;

      if (in_op) begin
         // Issue the operation once, then wait for the reducer to finish.
         if (!issued_ff) begin
            cmd.start = 1'b1;
            issued_in = 1'b1;
         end else if (status.done) begin
            issued_in = 1'b0;
            state_in  = op_next;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd.load = 1'b1;
                  state_in = S_RPOW;
               end
            end
            S_EMIT: begin
               // Load the output register once it is empty or being drained.
               if (!rsp_valid_ff || rsp_ready) begin
                  cmd.emit     = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> verif/modular_power_ternary_digits_top_tb.sv
// Self-checking testbench for modular_power_ternary_digits_top: streams ternary exponent digits,
// predicts each base^exponent mod modulus in a scoreboard class and compares every response.
// Depends on mptd_pkg and the top level in hw/rtl, with the files that the top level uses.
`timescale 1ns / 1ps

typedef bit [29:0] residue_type;

// Tracks the exponentiation state and holds the powers still owed by the block.
class power_mod_scoreboard;
   residue_type modulus_reg;
   residue_type running_power;
   residue_type accumulator;
   residue_type expected_powers[$];
   int unsigned failures;

   function new();
      modulus_reg   = 1;
      running_power = 0;
      accumulator   = 1;
      failures      = 0;
   endfunction

   function void set_modulus(residue_type value);
      modulus_reg = value;
   endfunction

   function bit [63:0] product_mod(bit [63:0] x, bit [63:0] y, bit [63:0] m);
      return ((x % m) * (y % m)) % m;
   endfunction

   function int unsigned pending();
      return expected_powers.size();
   endfunction

   // Applies one accepted request to the state and queues a power on a last digit.
   function void note_request(residue_type base_value, bit [1:0] digit, bit first_digit,
                              bit last_digit);
      bit [63:0] m;
      bit [63:0] square;
      // A zero modulus behaves as a modulus of one.
      m = (modulus_reg == 0) ? 64'd1 : {34'd0, modulus_reg};
      if (first_digit) begin
         running_power = residue_type'(base_value % m);
         accumulator   = 1;
      end
      // Digit three falls through and leaves the accumulator alone.
      if (digit == mptd_pkg::DIGIT_ONE) begin
         accumulator = residue_type'(product_mod(accumulator, running_power, m));
      end else if (digit == mptd_pkg::DIGIT_TWO) begin
         accumulator = residue_type'(product_mod(accumulator, running_power, m));
         accumulator = residue_type'(product_mod(accumulator, running_power, m));
      end
      square        = product_mod(running_power, running_power, m);
      running_power = residue_type'(product_mod(square, running_power, m));
      if (last_digit) begin
         expected_powers.push_back(residue_type'(accumulator % m));
      end
   endfunction

   // Compares one response against the oldest owed power.
   function void check_power(residue_type actual);
      residue_type expected;
      if (expected_powers.size() == 0) begin
         $error("power_mod: no result expected, actual %0d", actual);
         failures++;
         return;
      end
      expected = expected_powers.pop_front();
      if (actual !== expected) begin
         $error("power_mod: expected %0d, actual %0d", expected, actual);
         failures++;
      end
   endfunction
endclass

module modular_power_ternary_digits_top_tb;
   localparam int          VALUE_W       = 30;
   localparam residue_type MAX_VALUE     = 30'h3FFF_FFFF;
   localparam int          SETTLE_CYCLES = 400;
   localparam int          CYCLE_LIMIT   = 2_000_000;
   localparam int          SEGMENT_ITEMS = 175;
   localparam int          SEGMENTS      = 8;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [VALUE_W-1:0] csr_data = '0;

   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned cycle_count        = 0;
   power_mod_scoreboard sb = new();

   modular_power_ternary_digits_top #(
      .VALUE_WIDTH(VALUE_W)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #10 clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Response side: check accepted responses and stall at random.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_power(residue_type'(rsp_tdata[VALUE_W-1:0]));
      end
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Writes the modulus; only called while the block is idle.
   task automatic write_modulus(input residue_type value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.set_modulus(value);
   endtask

   // Offers one request, with an optional idle gap in front, and records it once taken.
   task automatic send_request(input residue_type base_value, input bit [1:0] digit,
                               input bit first_digit, input bit last_digit);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {digit, base_value};
      req_tuser  <= first_digit;
      req_tlast  <= last_digit;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(base_value, digit, first_digit, last_digit);
   endtask

   // Holds off new requests until every owed power has come and the block has settled.
   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Bases lean toward the edges of the current modulus and of the field.
   function automatic residue_type pick_base();
      residue_type m;
      m = sb.modulus_reg;
      case ($urandom_range(9))
         0: return 0;
         1: return MAX_VALUE;
         2: return m - 1;
         3: return m;
         4: return m + 1;
         default: return residue_type'($urandom);
      endcase
   endfunction

   function automatic bit [1:0] pick_digit();
      if ($urandom_range(9) == 0) return 2'd3;
      return 2'($urandom_range(2));
   endfunction

   // Mostly whole runs from a first digit to a last one, with some loose items mixed in.
   task automatic send_random_items(input int count);
      int sent;
      int run_len;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 85) begin
            run_len = ($urandom_range(9) == 0) ? $urandom_range(30, 20) : $urandom_range(8, 1);
            for (int i = 0; i < run_len; i++) begin
               send_request(pick_base(), pick_digit(), i == 0, i == run_len - 1);
            end
            sent += run_len;
         end else begin
            send_request(residue_type'($urandom), 2'($urandom_range(3)),
                         1'($urandom_range(1)), 1'($urandom_range(1)));
            sent++;
         end
      end
   endtask

   initial begin
      int unsigned sender_pcts[4];
      int unsigned receiver_pcts[4];
      residue_type seg_modulus;

      sender_pcts   = '{0, 51, 0, 21};
      receiver_pcts = '{0, 0, 51, 21};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part: digits before any start work on the reset state.
      write_modulus(1000003);
      send_request(777, 2'd0, 1'b0, 1'b1);
      send_request(777, 2'd1, 1'b0, 1'b1);
      // One-digit exponents with first and last together, including zero bases.
      send_request(MAX_VALUE, 2'd2, 1'b1, 1'b1);
      send_request(0, 2'd1, 1'b1, 1'b1);
      send_request(0, 2'd0, 1'b1, 1'b1);
      // A short run through every digit value, digit three included.
      send_request(2, 2'd1, 1'b1, 1'b0);
      send_request(0, 2'd2, 1'b0, 1'b0);
      send_request(0, 2'd0, 1'b0, 1'b0);
      send_request(0, 2'd3, 1'b0, 1'b0);
      send_request(0, 2'd1, 1'b0, 1'b1);
      // Bases at and just above the modulus.
      send_request(1000003, 2'd1, 1'b1, 1'b1);
      send_request(1000004, 2'd2, 1'b1, 1'b1);
      // The modulus changes in the middle of a run.
      send_request(12345, 2'd2, 1'b1, 1'b0);
      pause_until_drained();
      write_modulus(MAX_VALUE);
      send_request(0, 2'd1, 1'b0, 1'b0);
      send_request(0, 2'd2, 1'b0, 1'b1);
      send_request(MAX_VALUE, 2'd2, 1'b1, 1'b1);
      send_request(MAX_VALUE - 1, 2'd1, 1'b1, 1'b1);
      // A modulus of one, then of zero, returns only zeros.
      pause_until_drained();
      write_modulus(1);
      send_request(5, 2'd1, 1'b1, 1'b1);
      pause_until_drained();
      write_modulus(0);
      send_request(7, 2'd2, 1'b1, 1'b1);
      send_request(9, 2'd1, 1'b1, 1'b0);
      send_request(0, 2'd2, 1'b0, 1'b1);
      pause_until_drained();
      write_modulus(2);
      send_request(3, 2'd2, 1'b1, 1'b1);

      // Random part: one modulus and one idle profile per segment.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         pause_until_drained();
         case (seg)
            0: seg_modulus = 2;
            1: seg_modulus = MAX_VALUE;
            2: seg_modulus = 1000003;
            3: seg_modulus = residue_type'($urandom_range(255, 2));
            4: seg_modulus = 3;
            5: seg_modulus = residue_type'($urandom_range(32'h3FFF_FFFF, 1));
            6: seg_modulus = residue_type'($urandom_range(32'h3FFF_FFFF, 32'h3000_0000));
            default: seg_modulus = 1;
         endcase
         write_modulus(seg_modulus);
         sender_idle_pct    = sender_pcts[seg % 4];
         receiver_stall_pct = receiver_pcts[seg % 4];
         send_random_items(SEGMENT_ITEMS);
      end

      pause_until_drained();
      if (sb.failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
